@@ rtl/jsu_pkg.sv @@
// Package for the JSON string unescaper: shared command type, byte codes
// and queue sizing. No dependencies.
package jsu_pkg;

  // Byte codes of the escape scheme
  localparam logic [7:0] CharBsl   = 8'h5C;
  localparam logic [7:0] CharU     = 8'h75;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharB     = 8'h62;
  localparam logic [7:0] CharF     = 8'h66;
  localparam logic [7:0] CharN     = 8'h6E;
  localparam logic [7:0] CharR     = 8'h72;
  localparam logic [7:0] CharT     = 8'h74;
  localparam logic [7:0] CtlBs     = 8'h08;
  localparam logic [7:0] CtlFf     = 8'h0C;
  localparam logic [7:0] CtlLf     = 8'h0A;
  localparam logic [7:0] CtlCr     = 8'h0D;
  localparam logic [7:0] CtlTab    = 8'h09;
  localparam logic [7:0] CharNul   = 8'h00;

  // Most bytes a held prefix can hold: backslash, u and three zeros
  localparam logic [2:0] PrefixFull = 3'd5;

  // Command queue between classifier and emitter
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // One request's worth of output: a literal flush of pre_cnt held prefix
  // bytes, then an optional data byte, then an optional trailing backslash.
  typedef struct packed {
    logic [2:0] pre_cnt;
    logic       has_data;
    logic [7:0] data;
    logic       tail_bsl;
    logic       last;
  } cmd_t;

endpackage

@@ rtl/jsu_front.sv @@
// Classifier for the JSON string unescaper: tracks the held escape prefix and
// turns each request that yields output into a command. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [2:0] pm_q, pm_d;
  logic       accept;
  logic       fresh;
  logic       esc_hit;
  logic [7:0] esc_val;
  cmd_t       cmd;

  // Decode the single-character escapes
  always_comb begin
    esc_hit = 1'b1;
    esc_val = CharNul;
    unique case (in_byte_i)
      CharB:     esc_val = CtlBs;
      CharF:     esc_val = CtlFf;
      CharN:     esc_val = CtlLf;
      CharR:     esc_val = CtlCr;
      CharT:     esc_val = CtlTab;
      CharQuote: esc_val = CharQuote;
      CharBsl:   esc_val = CharBsl;
      default:   esc_hit = 1'b0;
    endcase
  end

  always_comb begin
    cmd   = '0;
    pm_d  = pm_q;
    fresh = 1'b0;
    priority if (pm_q == 3'd0) begin
      fresh = 1'b1;
    end else if (pm_q == 3'd1) begin
      if (esc_hit) begin
        cmd.has_data = 1'b1;
        cmd.data     = esc_val;
        pm_d         = 3'd0;
      end else if (in_byte_i == CharU) begin
        pm_d = 3'd2;
      end else begin
        cmd.pre_cnt = pm_q;
        fresh       = 1'b1;
      end
    end else if (pm_q < PrefixFull) begin
      if (in_byte_i == CharZero) begin
        pm_d = pm_q + 3'd1;
      end else begin
        cmd.pre_cnt = pm_q;
        fresh       = 1'b1;
      end
    end else begin
      if (in_byte_i == CharZero) begin
        cmd.has_data = 1'b1;
        cmd.data     = CharNul;
        pm_d         = 3'd0;
      end else begin
        cmd.pre_cnt = pm_q;
        fresh       = 1'b1;
      end
    end

    // Handle the byte afresh with nothing held
    if (fresh) begin
      if (in_byte_i == CharBsl) begin
        pm_d = 3'd1;
      end else begin
        cmd.has_data = 1'b1;
        cmd.data     = in_byte_i;
        pm_d         = 3'd0;
      end
    end

    // End of string: flush whatever is still held
    if (in_last_i) begin
      if (cmd.pre_cnt == 3'd0) begin
        cmd.pre_cnt = pm_d;
      end else begin
        cmd.tail_bsl = (pm_d != 3'd0);
      end
      cmd.last = 1'b1;
      pm_d     = 3'd0;
    end
  end

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept & ((cmd.pre_cnt != 3'd0) | cmd.has_data | cmd.tail_bsl);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 3'd0;
    end else if (accept) begin
      pm_q <= pm_d;
    end
  end

endmodule

@@ rtl/jsu_queue.sv @@
// Small command queue between classifier and emitter of the JSON string
// unescaper. Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/jsu_back.sv @@
// Emitter for the JSON string unescaper: steps through each queued command
// one byte a cycle while the output is not stalled, keeps the saturating
// length count and drives the output register. Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [12:0] out_length_o
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  logic [2:0]      pos_q, pos_d;
  logic [2:0]      total;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [31:0]     cnt_wide;
  logic            load;
  logic            at_end;
  logic            is_last;
  logic [7:0]      sel_byte;
  logic            valid_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic [12:0]     len_q;

  assign total   = head_i.pre_cnt + {2'b00, head_i.has_data} + {2'b00, head_i.tail_bsl};
  assign load    = ~empty_i & (~valid_q | out_ready_i);
  assign at_end  = (pos_q == total - 3'd1);
  assign is_last = head_i.last & at_end;
  assign pop_o   = load & at_end;

  // Pick the byte at the current position of the command
  always_comb begin
    if (pos_q < head_i.pre_cnt) begin
      priority if (pos_q == 3'd0) begin
        sel_byte = CharBsl;
      end else if (pos_q == 3'd1) begin
        sel_byte = CharU;
      end else begin
        sel_byte = CharZero;
      end
    end else if (head_i.has_data && (pos_q == head_i.pre_cnt)) begin
      sel_byte = head_i.data;
    end else begin
      sel_byte = CharBsl;
    end
  end

  assign cnt_inc  = (cnt_q < CntW'(MAX_LEN)) ? cnt_q + CntW'(1) : cnt_q;
  assign cnt_wide = 32'(cnt_inc);

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (load) begin
      pos_d = at_end ? 3'd0 : pos_q + 3'd1;
      cnt_d = is_last ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      last_q <= is_last;
      len_q  <= is_last ? cnt_wide[12:0] : 13'd0;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign out_length_o = len_q;

endmodule

@@ rtl/json_string_unescape_top.sv @@
// JSON string unescaper, top level. An accepted request's command is written
// into the command queue, and its first byte then into the output register;
// throughput one input byte per cycle while each byte yields at most one
// output byte, and one output byte per cycle overall while out_ready_i holds,
// set by the emitter that walks each command byte by byte. A command of up to
// six bytes holds the emitter. Reset (rst_ni low, asynchronous) drops the held
// prefix, the queue and the length count; no clearing pass is needed.
module json_string_unescape_top import jsu_pkg::*; #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Escaped input stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // Unescaped output stream
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [12:0] out_length_o
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // Front: hold any partial escape prefix and classify each request that yields
  // output into a command (literal flush, data byte, trailing backslash, end flag).
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // Queue: decouple the two sides so a long flush does not stall the front
  // until the queue fills.
  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (cmd_head)
  );

  // Back: emit one byte per cycle into the output register while it is not
  // stalled, advance the saturating length and stamp it on the string's final byte.
  jsu_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (cmd_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_length_o (out_length_o)
  );

endmodule
